// File: rtl/wcr_pkg.sv
package wcr_pkg;

  // sample and accumulator geometry
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int FPC_W       = 32;
  localparam int ACC_W       = FPC_W + 1;
  localparam int CENTER_W    = 11;
  localparam int GAIN_W      = 11;
  localparam int BASE_W      = 15;
  localparam int COL_W       = 16;
  localparam int ROW_W       = CENTER_W + 2;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int NUM_W       = CENTER_W + SAMPLE_BITS + 2;

  // accumulator step of one pair, 1.0 in Q16.16
  localparam logic [ACC_W-1:0] ACC_INC = ACC_W'(1) << FRAC_BITS;

  // register reset values
  localparam logic [FPC_W-1:0]    FPC_RESET    = FPC_W'(65536);
  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(64);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(128);

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_COLUMN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SAMPLE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_BASE        = 3'd4;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ROW_W-1:0]       row_t;
  typedef logic [COL_W-1:0]              col_t;

  typedef struct packed {
    col_t       column;
    row_t       row_from;
    row_t       row_to;
    logic       slanted;
    logic       run_end;
  } res_t;

  // gathered column events of one pair, sample domain
  typedef struct packed {
    logic    start;
    logic    emit;
    logic    last;
    sample_t emit_hi;
    sample_t emit_lo;
    sample_t fin_hi;
    sample_t fin_lo;
    col_t    emit_cnt;
    col_t    fin_cnt;
  } s1_t;

  // the same events, pixel domain
  typedef struct packed {
    logic start;
    logic emit;
    logic last;
    row_t emit_top;
    row_t emit_bot;
    row_t fin_top;
    row_t fin_bot;
    col_t emit_col;
    col_t fin_col;
  } s2_t;

  // round(center - sample * gain / 2), halves away from zero
  function automatic row_t row_of(sample_t s, logic [CENTER_W-1:0] c,
                                  logic [GAIN_W-1:0] g);
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         mag;
    logic [NUM_W-1:0]         rsum;
    logic [ROW_W-1:0]         q;
    prod = PROD_W'(s) * PROD_W'($signed({1'b0, g}));
    num  = $signed({{(NUM_W-CENTER_W-SAMPLE_BITS){1'b0}}, c, {SAMPLE_BITS{1'b0}}})
         - $signed({{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod});
    mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rsum = mag + (NUM_W'(1) << (SAMPLE_BITS - 1));
    q    = ROW_W'(rsum >> SAMPLE_BITS);
    return num[NUM_W-1] ? row_t'(-q) : row_t'(q);
  endfunction

endpackage

// File: rtl/waveform_column_renderer_top.sv
// Min/max waveform column renderer. Peak pairs (high, low; signed Q1.15) enter on the in_
// stream, one per cycle; a pair of the run that closes a column gives one line, the pair
// marked tlast gives the final vertical line as well. Lines leave on the out_ stream,
// one per cycle, through an 8-entry queue; an input pair is taken only while the queue
// has room for two lines from every pair still in flight, so the sustained rate is one
// pair a cycle while pairs average no more than one line each, and otherwise the output
// port (one line a cycle) sets it. From input to first visible line a pair passes the
// accumulator register, the row multiply register, then stretch and write into the queue.
// Configuration writes are always taken and must only be made while no pair is pending.
module waveform_column_renderer_top (
  input  logic        clk,
  input  logic        rst_n,
  // pair stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // high_sample[15:0], low_sample[31:16]
  input  logic        in_tlast,   // last_pair
  // line stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // column[15:0], row_from[28:16], row_to[41:29], zero pad
  output logic        out_tuser,  // slanted
  output logic        out_tlast,  // run_end
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [wcr_pkg::FPC_W-1:0]    fpc_r;
  logic [wcr_pkg::CENTER_W-1:0] center_r;
  logic [wcr_pkg::GAIN_W-1:0]   gain_r;
  logic                         ssm_r;
  logic [wcr_pkg::BASE_W-1:0]   base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpc_r    <= wcr_pkg::FPC_RESET;
      center_r <= wcr_pkg::CENTER_RESET;
      gain_r   <= wcr_pkg::GAIN_RESET;
      ssm_r    <= 1'b0;
      base_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wcr_pkg::REG_FRAMES_PER_COLUMN:  fpc_r    <= cfg_data;
        wcr_pkg::REG_CENTER_ROW:         center_r <= cfg_data[wcr_pkg::CENTER_W-1:0];
        wcr_pkg::REG_VERTICAL_GAIN:      gain_r   <= cfg_data[wcr_pkg::GAIN_W-1:0];
        wcr_pkg::REG_SINGLE_SAMPLE_MODE: ssm_r    <= cfg_data[0];
        wcr_pkg::REG_COLUMN_BASE:        base_r   <= cfg_data[wcr_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage a
  logic                       run_started_r, run_started_nxt;
  logic [wcr_pkg::ACC_W-1:0]  frame_accum_r, frame_accum_nxt;
  wcr_pkg::sample_t           run_high_r, run_high_nxt;
  wcr_pkg::sample_t           run_low_r, run_low_nxt;
  wcr_pkg::col_t              column_count_r, column_count_nxt;

  logic                       in_acc;
  wcr_pkg::sample_t           hi, lo;
  logic                       start_a, emit_a;
  logic [wcr_pkg::ACC_W-1:0]  acc0, acc_sub;
  logic [wcr_pkg::ACC_W:0]    acc_sum;
  wcr_pkg::sample_t           rh0, rl0, rh1, rl1;
  wcr_pkg::col_t              cc0;
  wcr_pkg::s1_t               s1_nxt, s1_r;
  logic                       s1_valid_r;

  assign in_acc = in_tvalid && in_tready;
  assign hi     = wcr_pkg::sample_t'(in_tdata[15:0]);
  assign lo     = wcr_pkg::sample_t'(in_tdata[31:16]);

  // accumulator compare and min/max gathering
  always_comb begin
    start_a = !run_started_r;
    acc0    = start_a ? '0 : frame_accum_r;
    cc0     = start_a ? '0 : column_count_r;
    rh0     = start_a ? hi : run_high_r;
    rl0     = start_a ? lo : run_low_r;
    emit_a  = acc0 >= wcr_pkg::ACC_W'(fpc_r);
    acc_sub = emit_a ? acc0 - wcr_pkg::ACC_W'(fpc_r) : acc0;
    acc_sum = {1'b0, acc_sub} + {1'b0, wcr_pkg::ACC_INC};
    frame_accum_nxt  = acc_sum[wcr_pkg::ACC_W] ? '1 : acc_sum[wcr_pkg::ACC_W-1:0];
    column_count_nxt = emit_a ? cc0 + wcr_pkg::COL_W'(1) : cc0;
    rh1 = emit_a ? hi : rh0;
    rl1 = emit_a ? lo : rl0;
    run_high_nxt = (hi > rh1) ? hi : rh1;
    run_low_nxt  = (lo < rl1) ? lo : rl1;
    run_started_nxt = !in_tlast;

    s1_nxt.start    = start_a;
    s1_nxt.emit     = emit_a;
    s1_nxt.last     = in_tlast;
    s1_nxt.emit_hi  = rh0;
    s1_nxt.emit_lo  = rl0;
    s1_nxt.fin_hi   = run_high_nxt;
    s1_nxt.fin_lo   = run_low_nxt;
    s1_nxt.emit_cnt = cc0;
    s1_nxt.fin_cnt  = column_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_started_r  <= 1'b0;
      frame_accum_r  <= '0;
      run_high_r     <= '0;
      run_low_r      <= '0;
      column_count_r <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        run_started_r  <= run_started_nxt;
        frame_accum_r  <= frame_accum_nxt;
        run_high_r     <= run_high_nxt;
        run_low_r      <= run_low_nxt;
        column_count_r <= column_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage b
  wcr_pkg::s2_t  s2_nxt, s2_r;
  logic          s2_valid_r;
  wcr_pkg::col_t base_col;

  // sample to pixel row, one multiply per row
  always_comb begin
    base_col        = wcr_pkg::COL_W'(base_r);
    s2_nxt.start    = s1_r.start;
    s2_nxt.emit     = s1_r.emit;
    s2_nxt.last     = s1_r.last;
    s2_nxt.emit_top = wcr_pkg::row_of(s1_r.emit_hi, center_r, gain_r);
    s2_nxt.emit_bot = wcr_pkg::row_of(s1_r.emit_lo, center_r, gain_r);
    s2_nxt.fin_top  = wcr_pkg::row_of(s1_r.fin_hi, center_r, gain_r);
    s2_nxt.fin_bot  = wcr_pkg::row_of(s1_r.fin_lo, center_r, gain_r);
    s2_nxt.emit_col = base_col + s1_r.emit_cnt;
    s2_nxt.fin_col  = base_col + s1_r.fin_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------- stage c
  wcr_pkg::row_t prev_top_r, prev_top_nxt;
  wcr_pkg::row_t prev_bot_r, prev_bot_nxt;
  logic          first_r, first_nxt;
  wcr_pkg::row_t pt, pb, a_row, b_row;
  logic          first_c;
  wcr_pkg::res_t emit_res, fin_res, push0, push1;
  logic [1:0]    n_push;

  // stretch against the previous column, or slant from its top
  always_comb begin
    pt      = s2_r.start ? wcr_pkg::row_t'({2'b00, center_r}) : prev_top_r;
    pb      = s2_r.start ? wcr_pkg::row_t'({2'b00, center_r}) : prev_bot_r;
    first_c = s2_r.start ? 1'b1 : first_r;
    a_row   = s2_r.emit_top;
    b_row   = s2_r.emit_bot;
    if (!first_c) begin
      if (a_row > pb) a_row = pb + wcr_pkg::row_t'(1);
      if (b_row < pt) b_row = pt - wcr_pkg::row_t'(1);
    end

    emit_res.column  = s2_r.emit_col;
    emit_res.run_end = 1'b0;
    if (ssm_r) begin
      emit_res.row_from = pt;
      emit_res.row_to   = s2_r.emit_top;
      emit_res.slanted  = 1'b1;
    end else begin
      emit_res.row_from = a_row;
      emit_res.row_to   = b_row;
      emit_res.slanted  = 1'b0;
    end

    fin_res.column   = s2_r.fin_col;
    fin_res.row_from = s2_r.fin_top;
    fin_res.row_to   = s2_r.fin_bot;
    fin_res.slanted  = 1'b0;
    fin_res.run_end  = 1'b1;

    push0  = s2_r.emit ? emit_res : fin_res;
    push1  = fin_res;
    n_push = s2_valid_r ? (2'({1'b0, s2_r.emit}) + 2'({1'b0, s2_r.last})) : 2'd0;

    prev_top_nxt = s2_r.emit ? s2_r.emit_top : pt;
    prev_bot_nxt = s2_r.emit ? s2_r.emit_bot : pb;
    first_nxt    = (s2_r.emit && !ssm_r) ? 1'b0 : first_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_top_r <= '0;
      prev_bot_r <= '0;
      first_r    <= 1'b1;
    end else if (s2_valid_r) begin
      prev_top_r <= prev_top_nxt;
      prev_bot_r <= prev_bot_nxt;
      first_r    <= first_nxt;
    end
  end

  // ---------------------------------------------------------------- line queue
  wcr_pkg::res_t                fifo_r [wcr_pkg::FIFO_DEPTH];
  logic [wcr_pkg::PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [wcr_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [wcr_pkg::CNT_W-1:0]    used_r, used_nxt;
  logic                         pop;
  wcr_pkg::res_t                head;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = count_r != '0;
  assign head       = fifo_r[rd_ptr_r];
  assign out_tdata  = {6'b0, head.row_to, head.row_from, head.column};
  assign out_tuser  = head.slanted;
  assign out_tlast  = head.run_end;

  // every pair in flight holds room for two lines until its lines are known
  assign in_tready = used_r <= wcr_pkg::CNT_W'(wcr_pkg::FIFO_DEPTH - 2);

  always_comb begin
    count_nxt = count_r + wcr_pkg::CNT_W'(n_push) - wcr_pkg::CNT_W'(pop);
    used_nxt  = used_r
              + (in_acc ? wcr_pkg::CNT_W'(2) : '0)
              - (s2_valid_r ? wcr_pkg::CNT_W'(2'd2 - n_push) : '0)
              - wcr_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + wcr_pkg::PTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + wcr_pkg::PTR_W'(pop);
      count_r  <= count_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + wcr_pkg::PTR_W'(1)] <= push1;
    end
  end

`ifndef SYNTH
  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wcr_pkg::CNT_W'(wcr_pkg::FIFO_DEPTH))
    else $error("line queue overflow");

  // reserved room always covers the stored lines
  a_used_covers: assert property (@(posedge clk) disable iff (!rst_n)
    used_r >= count_r && used_r <= wcr_pkg::CNT_W'(wcr_pkg::FIFO_DEPTH))
    else $error("reservation count out of step with queue");

  // with the pipeline empty nothing stays reserved beyond the queue
  a_used_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !s2_valid_r) |-> used_r == count_r)
    else $error("reservation leak after pipeline drained");
`endif

endmodule
